// ===== rtl/idea_pkg.sv =====
// shared types, constants and arithmetic helpers for the idea cipher block
package idea_pkg;

    localparam int ROUND_COUNT  = 8;
    localparam int SUBKEY_TOTAL = 52;
    localparam int ROW_COUNT    = ROUND_COUNT + 1;
    localparam int KMEM_DEPTH   = 2 * ROW_COUNT;
    localparam int KMEM_AW      = $clog2(KMEM_DEPTH);
    localparam int ROW_W        = $clog2(ROW_COUNT);
    localparam int SK_IDX_W     = $clog2(SUBKEY_TOTAL);

    // register indexes of the configuration port
    localparam int               CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

    typedef logic [5:0][15:0]              row_t;
    typedef logic [SUBKEY_TOTAL-1:0][15:0] sk_arr_t;

    typedef struct packed {
        logic               en;
        logic [KMEM_AW-1:0] addr;
        row_t               data;
    } kmem_wr_t;

    typedef enum logic [2:0] {
        KS_IDLE,
        KS_FWD,
        KS_INVA,
        KS_INVB,
        KS_WINV
    } ks_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MIX,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } rnd_state_t;

    // multiplication mod 65537, a zero word stands for 65536
    function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] r;
        p  = {16'd0, a} * {16'd0, b};
        lo = p[15:0];
        hi = p[31:16];
        if (a == 16'd0)
            r = 16'd1 - b;
        else if (b == 16'd0)
            r = 16'd1 - a;
        else
            r = lo - hi + {15'd0, (lo < hi)};
        return r;
    endfunction

    function automatic logic [15:0] neg_mod(input logic [15:0] a);
        return 16'd0 - a;
    endfunction

    // all forward subkeys: word i%8 of the key rotated left by 25*(i/8), modulo 128
    function automatic sk_arr_t fwd_keys(input logic [127:0] key);
        sk_arr_t      sk;
        logic [255:0] dbl;
        logic [127:0] rot;
        logic [127:0] sh;
        for (int i = 0; i < SUBKEY_TOTAL; i++) begin
            dbl   = {key, key} << ((25 * (i >> 3)) % 128);
            rot   = dbl[255:128];
            sh    = rot >> (16 * (7 - (i & 7)));
            sk[i] = sh[15:0];
        end
        return sk;
    endfunction

endpackage

// ===== rtl/idea_kmem.sv =====
// subkey memory: one row of six subkeys per round, forward rows then inverse rows
module idea_kmem (
    input  logic                        clk,
    input  idea_pkg::kmem_wr_t          wr,
    input  logic                        rd_en,
    input  logic [idea_pkg::KMEM_AW-1:0] rd_addr,
    output idea_pkg::row_t              rd_data
);
    import idea_pkg::*;

    row_t mem [KMEM_DEPTH];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/idea_ks.sv =====
// key schedule sequencer: writes forward rows and inverse rows into the subkey memory
module idea_ks (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        key_high,
    input  logic [63:0]        key_low,
    output logic               busy,
    output idea_pkg::kmem_wr_t wr
);
    import idea_pkg::*;

    ks_state_t state_reg, state_next;
    logic [ROW_W-1:0] row_reg;
    logic [15:0]      acc_reg;
    logic [15:0]      base_reg;
    logic [15:0]      inv_a_reg;
    logic [3:0]       step_reg;
    logic             sq_reg;

    sk_arr_t     sk;
    row_t        fwd_row;
    row_t        inv_row;
    logic [15:0] prod;
    logic        inv_done;
    logic        row_last;
    logic        edge_row;
    logic [6:0]  fbase;
    logic [6:0]  sbase;
    logic [6:0]  pbase;
    logic [6:0]  idx;

    assign sk       = fwd_keys({key_high, key_low});
    assign prod     = mul_mod(acc_reg, sq_reg ? acc_reg : base_reg);
    assign inv_done = !sq_reg && (step_reg == 4'd14);
    assign row_last = (row_reg == ROW_W'(ROUND_COUNT));
    assign edge_row = (row_reg == '0) || row_last;

    // subkey groups of the current row
    assign fbase = 7'(row_reg) * 7'd6;
    assign sbase = 7'(ROUND_COUNT - 32'(row_reg)) * 7'd6;
    assign pbase = 7'(ROUND_COUNT - 1 - 32'(row_reg)) * 7'd6;

    always_comb
    begin
        idx = '0;
        for (int j = 0; j < 6; j++)
        begin
            idx = fbase + 7'(j);
            if (idx < 7'(SUBKEY_TOTAL))
                fwd_row[j] = sk[idx[SK_IDX_W-1:0]];
            else
                fwd_row[j] = '0;
        end
    end

    always_comb
    begin
        inv_row[0] = inv_a_reg;
        inv_row[3] = acc_reg;
        if (edge_row)
        begin
            inv_row[1] = neg_mod(sk[6'(sbase + 7'd1)]);
            inv_row[2] = neg_mod(sk[6'(sbase + 7'd2)]);
        end
        else
        begin
            inv_row[1] = neg_mod(sk[6'(sbase + 7'd2)]);
            inv_row[2] = neg_mod(sk[6'(sbase + 7'd1)]);
        end
        if (!row_last)
        begin
            inv_row[4] = sk[6'(pbase + 7'd4)];
            inv_row[5] = sk[6'(pbase + 7'd5)];
        end
        else
        begin
            inv_row[4] = '0;
            inv_row[5] = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            KS_IDLE: state_next = KS_IDLE;
            KS_FWD:  state_next = KS_INVA;
            KS_INVA: if (inv_done) state_next = KS_INVB;
            KS_INVB: if (inv_done) state_next = KS_WINV;
            KS_WINV: state_next = row_last ? KS_IDLE : KS_FWD;
            default: state_next = KS_IDLE;
        endcase
        if (start)
            state_next = KS_FWD;
    end

    // outputs
    always_comb
    begin
        busy    = 1'b1;
        wr.en   = 1'b0;
        wr.addr = KMEM_AW'(row_reg);
        wr.data = fwd_row;
        unique case (state_reg)
            KS_IDLE: busy = 1'b0;
            KS_FWD:  wr.en = 1'b1;
            KS_INVA: wr.en = 1'b0;
            KS_INVB: wr.en = 1'b0;
            KS_WINV:
            begin
                wr.en   = 1'b1;
                wr.addr = KMEM_AW'(ROW_COUNT) + KMEM_AW'(row_reg);
                wr.data = inv_row;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_FWD;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
                row_reg <= '0;
            else if (state_reg == KS_WINV && !row_last)
                row_reg <= row_reg + 1'b1;
        end
    end

    // inversion by raising to the power 65535: fifteen square-and-multiply steps
    always_ff @(posedge clk)
    begin
        case (state_reg)
            KS_FWD:
            begin
                acc_reg  <= sk[6'(sbase)];
                base_reg <= sk[6'(sbase)];
                step_reg <= '0;
                sq_reg   <= 1'b1;
            end
            KS_INVA:
            begin
                if (inv_done)
                begin
                    inv_a_reg <= prod;
                    acc_reg   <= sk[6'(sbase + 7'd3)];
                    base_reg  <= sk[6'(sbase + 7'd3)];
                    step_reg  <= '0;
                    sq_reg    <= 1'b1;
                end
                else
                begin
                    acc_reg <= prod;
                    sq_reg  <= !sq_reg;
                    if (!sq_reg)
                        step_reg <= step_reg + 1'b1;
                end
            end
            KS_INVB:
            begin
                acc_reg <= prod;
                sq_reg  <= !sq_reg;
                if (!sq_reg)
                    step_reg <= step_reg + 1'b1;
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end

endmodule

// ===== rtl/idea_block_cipher_top.sv =====
// top level of the idea cipher block: configuration, round sequencer and datapath
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     data_block   (64 bits)
//  output    out        out_valid / out_stall   result_block (64 bits)
//  config    in         cfg_write               cfg_index, cfg_data (64 bits)
//
// from acceptance to the next acceptance a word passes through one subkey row read,
// eight rounds on the shared round unit (two dependent mod-65537 multiplies each),
// the output half-round and the load of the result
// after reset and after every key write the schedule fills the subkey memory row by row
// (nine rows of one forward write, two inversions, one inverse write);
// no input word is accepted meanwhile
// a finished word waits in the output register; a new input word is taken while it waits
module idea_block_cipher_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [63:0]                    data_block,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [63:0]                    result_block,
    input  logic                           cfg_write,
    input  logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import idea_pkg::*;

    // configuration registers
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        direction_reg;
    logic        ks_start;
    logic        ks_busy;

    // round sequencer and datapath
    rnd_state_t  state_reg, state_next;
    logic [ROW_W-1:0] round_reg;
    logic [15:0] x0_reg, x1_reg, x2_reg, x3_reg;
    logic [15:0] t0_reg;
    logic [63:0] result_reg;
    logic        out_valid_reg;

    kmem_wr_t         kwr;
    logic             rd_en;
    logic [KMEM_AW-1:0] rd_addr;
    row_t             k;

    logic        in_take;
    logic        out_free;
    logic        last_round;
    logic [15:0] t1;
    logic [15:0] t2;

    assign in_take    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign last_round = (round_reg == ROW_W'(ROUND_COUNT));

    // a key write restarts the schedule
    assign ks_start = cfg_write && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            direction_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_HIGH:  key_high_reg  <= cfg_data;
                REG_KEY_LOW:   key_low_reg   <= cfg_data;
                REG_DIRECTION: direction_reg <= cfg_data[0];
                default:       direction_reg <= direction_reg;
            endcase
        end
    end

    idea_ks u_ks (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ks_start),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .busy     (ks_busy),
        .wr       (kwr)
    );

    idea_kmem u_kmem (
        .clk     (clk),
        .wr      (kwr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (k)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_READ;
            ST_READ: state_next = ST_MIX;
            ST_MIX:  state_next = last_round ? ST_DONE : ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_MIX;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: subkey row reads, the input stall
    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        // forward rows first, inverse rows after them
        rd_addr  = (direction_reg ? KMEM_AW'(ROW_COUNT) : KMEM_AW'(0)) + KMEM_AW'(round_reg);
        unique case (state_reg)
            ST_IDLE: in_stall = ks_busy;
            ST_READ: rd_en = 1'b1;
            ST_MIX:  rd_en = 1'b0;
            ST_MUL:  rd_en = 1'b0;
            ST_ADD:
            begin
                // fetch the next round's row while this round finishes
                rd_en   = 1'b1;
                rd_addr = (direction_reg ? KMEM_AW'(ROW_COUNT) : KMEM_AW'(0))
                          + KMEM_AW'(round_reg) + KMEM_AW'(1);
            end
            ST_DONE: in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // second multiply of the mixing layer and the sum that feeds the closing xors
    assign t1 = mul_mod(k[5], t0_reg + (x1_reg ^ x3_reg));
    assign t2 = t0_reg + t1;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    x0_reg    <= data_block[63:48];
                    x1_reg    <= data_block[47:32];
                    x2_reg    <= data_block[31:16];
                    x3_reg    <= data_block[15:0];
                    round_reg <= '0;
                end
            end
            ST_MIX:
            begin
                x0_reg <= mul_mod(x0_reg, k[0]);
                x3_reg <= mul_mod(x3_reg, k[3]);
                if (last_round)
                begin
                    // output half-round undoes the last swap
                    x1_reg <= x2_reg + k[1];
                    x2_reg <= x1_reg + k[2];
                end
                else
                begin
                    x1_reg <= x1_reg + k[1];
                    x2_reg <= x2_reg + k[2];
                end
            end
            ST_MUL:
            begin
                t0_reg <= mul_mod(k[4], x0_reg ^ x2_reg);
            end
            ST_ADD:
            begin
                x0_reg    <= x0_reg ^ t1;
                x3_reg    <= x3_reg ^ t2;
                x1_reg    <= x2_reg ^ t1;
                x2_reg    <= x1_reg ^ t2;
                round_reg <= round_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                    result_reg <= {x0_reg, x1_reg, x2_reg, x3_reg};
            end
            default:
            begin
                t0_reg <= t0_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_block = result_reg;

endmodule
